// ===== src/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

    // sizing
    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;
    localparam int EDGE_AW     = $clog2(MAX_EDGES);
    localparam int EDGE_CW     = EDGE_AW + 1;
    localparam int OFF_W       = EDGE_CW;
    localparam int OFF_DEPTH   = MAX_NODES + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // request codes
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  component_total;
        logic [NODE_W-1:0] first_component;
        logic [NODE_W-1:0] second_component;
        logic              same_component;
    } t_out_word;

    // classified command held in the queue
    typedef struct packed {
        t_req              op;
        logic              range_err;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
    } t_cmd;

    // queue head as seen by the engine
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // one walk stack frame
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [OFF_W-1:0]  pos;
        logic [OFF_W-1:0]  fin;
    } t_frame;

    typedef enum logic [4:0] {
        ES_IDLE,
        ES_REPLY,
        ES_QRY_RD,
        ES_QRY_OUT,
        ES_CLR,
        ES_CNT_RD,
        ES_CNT_W,
        ES_CNT_UPD,
        ES_PRE_RD,
        ES_PRE_WR,
        ES_PLC_RD,
        ES_PLC_W,
        ES_PLC_UPD,
        ES_OUT_RD,
        ES_OUT_W,
        ES_START,
        ES_LOAD,
        ES_STEP,
        ES_STEP_W,
        ES_VIS_W,
        ES_POP_W,
        ES_VCLR,
        ES_FIN_RD,
        ES_FIN_W,
        ES_REV_VIS,
        ES_DONE
    } t_eng_state;

endpackage
`default_nettype wire

// ===== src/strongly_connected_components_unit.sv =====
`default_nettype none
// Strongly connected components unit (Kosaraju, two depth-first passes).
// Input channel: a request word is taken at a clock edge with i_start high
// and o_busy low. Request 0 stores an edge, 1 solves, 2 queries two nodes.
// Node count register: written with i_cfg_we / i_cfg_wdata while idle.
// Output channel: o_res_valid marks each result word for one cycle; the
// receiver cannot stall it, so every result must be taken when shown.
// A two-word queue sits between the accepting front and the solver engine,
// so o_busy rises only when both queue slots hold waiting words.
// An edge load passes the queue, the idle and reply states; a query
// passes the queue, the idle, read and output states. The queue takes
// new words while a slot is free, also while the engine is busy.
// Solve: the sequencer steps through its memories phase by phase
// (offset clear, degree count, running sum, list placement, two walks).
// Reset: queue empty, no edges stored, component count 0, every node
// reads as component 0 until a solve covers it.
module strongly_connected_components_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire scc_pkg::t_in_word         i_req_word,
    input  wire logic                      i_cfg_we,
    input  wire logic [scc_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                           o_res_valid,
    output scc_pkg::t_out_word             o_res_word
);
    import scc_pkg::*;

    t_head            head;
    logic             pop;
    logic [CNT_W-1:0] nodes;

    // accept and classify
    scc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req_word  (i_req_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_head      (head),
        .i_pop       (pop),
        .o_nodes     (nodes)
    );

    // carry out
    scc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_nodes     (nodes),
        .o_res_valid (o_res_valid),
        .o_res_word  (o_res_word)
    );

`ifndef SYNTH
    // results never come in adjacent cycles
    a_res_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("back-to-back result words");

    // the engine pops only a word that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    // same flag agrees with the component fields
    a_same_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res_word.same_component) |->
        (o_res_word.first_component == o_res_word.second_component))
        else $error("same flag with differing components");

    // unused status code never reported
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res_word.status != 2'd3))
        else $error("bad status code");
`endif

endmodule
`default_nettype wire

// ===== src/scc_front.sv =====
`default_nettype none
module scc_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire scc_pkg::t_in_word        i_req_word,
    input  wire logic                     i_cfg_we,
    input  wire logic [scc_pkg::CNT_W-1:0] i_cfg_wdata,
    output scc_pkg::t_head                o_head,
    input  wire logic                     i_pop,
    output logic [scc_pkg::CNT_W-1:0]     o_nodes
);
    import scc_pkg::*;

    logic [CNT_W-1:0]    r_node_count;
    t_cmd                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push;
    t_cmd                cmd;

    // node count register, saturated on use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    assign o_nodes = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;

    // classify the incoming word
    always_comb begin
        cmd.op        = t_req'(i_req_word.req_type);
        cmd.a         = i_req_word.source_node;
        cmd.b         = i_req_word.target_node;
        cmd.range_err = ({1'b0, i_req_word.source_node} >= o_nodes) ||
                        ({1'b0, i_req_word.target_node} >= o_nodes);
    end

    assign o_busy = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;

    // short command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule
`default_nettype wire

// ===== src/scc_engine.sv =====
`default_nettype none
module scc_engine (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire scc_pkg::t_head            i_head,
    output logic                           o_pop,
    input  wire logic [scc_pkg::CNT_W-1:0] i_nodes,
    output logic                           o_res_valid,
    output scc_pkg::t_out_word             o_res_word
);
    import scc_pkg::*;

    // memories
    logic [NODE_W-1:0] es_mem [MAX_EDGES];
    logic [NODE_W-1:0] et_mem [MAX_EDGES];
    logic [OFF_W-1:0]  fo_mem [OFF_DEPTH];
    logic [OFF_W-1:0]  ro_mem [OFF_DEPTH];
    logic [OFF_W-1:0]  ff_mem [MAX_NODES];
    logic [OFF_W-1:0]  rf_mem [MAX_NODES];
    logic [NODE_W-1:0] fl_mem [MAX_EDGES];
    logic [NODE_W-1:0] rl_mem [MAX_EDGES];
    logic              vis_mem [MAX_NODES];
    logic [NODE_W-1:0] fin_mem [MAX_NODES];
    t_frame            stk_mem [MAX_NODES];
    logic [NODE_W-1:0] cp_mem [MAX_NODES];

    // registers
    t_eng_state        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [EDGE_CW-1:0] r_e, n_e;
    logic [EDGE_CW-1:0] r_edge_total, n_edge_total;
    logic [OFF_W-1:0]  r_sum_f, n_sum_f, r_sum_r, n_sum_r;
    logic [CNT_W-1:0]  r_fin_cnt, n_fin_cnt;
    logic [CNT_W-1:0]  r_label, n_label;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic [NODE_W-1:0] r_top_v, n_top_v;
    logic [OFF_W-1:0]  r_top_p, n_top_p;
    logic [OFF_W-1:0]  r_top_end, n_top_end;
    logic [NODE_W-1:0] r_w, n_w;
    logic              r_pass, n_pass;
    logic [CNT_W-1:0]  r_comp_total, n_comp_total;
    logic [CNT_W-1:0]  r_hwm, n_hwm;
    logic              r_o_valid, n_o_valid;
    t_out_word         r_o_res, n_o_res;

    // read data
    logic [NODE_W-1:0] r_es_rd, r_et_rd;
    logic [OFF_W-1:0]  r_fo_rd0, r_fo_rd1, r_ro_rd0, r_ro_rd1;
    logic [OFF_W-1:0]  r_ff_rd, r_rf_rd;
    logic [NODE_W-1:0] r_fl_rd, r_rl_rd;
    logic              r_vis_rd;
    logic [NODE_W-1:0] r_fin_rd;
    t_frame            r_stk_rd;
    logic [NODE_W-1:0] r_cp_rd0, r_cp_rd1;

    // port controls
    logic              e_we;
    logic              fo_we, ro_we;
    logic [CNT_W-1:0]  fo_wa, ro_wa, fo_ra0, fo_ra1, ro_ra0, ro_ra1;
    logic [OFF_W-1:0]  fo_wd, ro_wd;
    logic              ff_we, rf_we;
    logic [NODE_W-1:0] ff_wa, rf_wa, ff_ra, rf_ra;
    logic [OFF_W-1:0]  ff_wd, rf_wd;
    logic              fl_we, rl_we;
    logic [EDGE_AW-1:0] fl_wa, rl_wa, lst_ra;
    logic [NODE_W-1:0] fl_wd, rl_wd;
    logic              vis_we, vis_wd;
    logic [NODE_W-1:0] vis_wa, vis_ra;
    logic              fin_we;
    logic [NODE_W-1:0] fin_wa, fin_wd, fin_ra;
    logic              stk_we;
    logic [NODE_W-1:0] stk_wa, stk_ra;
    t_frame            stk_wd;
    logic              cp_we;
    logic [NODE_W-1:0] cp_wa, cp_wd;

    // helpers
    logic [NODE_W-1:0] s, t;
    logic              edge_ok;
    logic [OFF_W-1:0]  cur_off0, cur_off1;
    logic [NODE_W-1:0] cur_list;
    logic [NODE_W-1:0] q_c1, q_c2;

    assign s        = r_es_rd;
    assign t        = r_et_rd;
    assign edge_ok  = ({1'b0, s} < r_n) && ({1'b0, t} < r_n);
    assign cur_off0 = r_pass ? r_ro_rd0 : r_fo_rd0;
    assign cur_off1 = r_pass ? r_ro_rd1 : r_fo_rd1;
    assign cur_list = r_pass ? r_rl_rd : r_fl_rd;
    assign q_c1     = ({1'b0, r_cmd.a} < r_hwm) ? r_cp_rd0 : '0;
    assign q_c2     = ({1'b0, r_cmd.b} < r_hwm) ? r_cp_rd1 : '0;

    // edge store
    always_ff @(posedge i_clk) begin
        if (e_we) begin
            es_mem[r_edge_total[EDGE_AW-1:0]] <= r_cmd.a;
            et_mem[r_edge_total[EDGE_AW-1:0]] <= r_cmd.b;
        end
        r_es_rd <= es_mem[r_e[EDGE_AW-1:0]];
        r_et_rd <= et_mem[r_e[EDGE_AW-1:0]];
    end

    // offsets, two reads each
    always_ff @(posedge i_clk) begin
        if (fo_we) begin
            fo_mem[fo_wa] <= fo_wd;
        end
        if (ro_we) begin
            ro_mem[ro_wa] <= ro_wd;
        end
        r_fo_rd0 <= fo_mem[fo_ra0];
        r_fo_rd1 <= fo_mem[fo_ra1];
        r_ro_rd0 <= ro_mem[ro_ra0];
        r_ro_rd1 <= ro_mem[ro_ra1];
    end

    // fill pointers
    always_ff @(posedge i_clk) begin
        if (ff_we) begin
            ff_mem[ff_wa] <= ff_wd;
        end
        if (rf_we) begin
            rf_mem[rf_wa] <= rf_wd;
        end
        r_ff_rd <= ff_mem[ff_ra];
        r_rf_rd <= rf_mem[rf_ra];
    end

    // adjacency lists
    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            fl_mem[fl_wa] <= fl_wd;
        end
        if (rl_we) begin
            rl_mem[rl_wa] <= rl_wd;
        end
        r_fl_rd <= fl_mem[lst_ra];
        r_rl_rd <= rl_mem[lst_ra];
    end

    // visited, finish order, stack, components
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        r_vis_rd <= vis_mem[vis_ra];
        if (fin_we) begin
            fin_mem[fin_wa] <= fin_wd;
        end
        r_fin_rd <= fin_mem[fin_ra];
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= stk_mem[stk_ra];
        if (cp_we) begin
            cp_mem[cp_wa] <= cp_wd;
        end
        r_cp_rd0 <= cp_mem[r_cmd.a];
        r_cp_rd1 <= cp_mem[r_cmd.b];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ES_IDLE;
            r_edge_total <= '0;
            r_comp_total <= '0;
            r_hwm        <= '0;
            r_o_valid    <= 1'b0;
            r_pass       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_comp_total <= n_comp_total;
            r_hwm        <= n_hwm;
            r_o_valid    <= n_o_valid;
            r_pass       <= n_pass;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_n       <= n_n;
        r_i       <= n_i;
        r_e       <= n_e;
        r_sum_f   <= n_sum_f;
        r_sum_r   <= n_sum_r;
        r_fin_cnt <= n_fin_cnt;
        r_label   <= n_label;
        r_depth   <= n_depth;
        r_top_v   <= n_top_v;
        r_top_p   <= n_top_p;
        r_top_end <= n_top_end;
        r_w       <= n_w;
        r_o_res   <= n_o_res;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_n          = r_n;
        n_i          = r_i;
        n_e          = r_e;
        n_edge_total = r_edge_total;
        n_sum_f      = r_sum_f;
        n_sum_r      = r_sum_r;
        n_fin_cnt    = r_fin_cnt;
        n_label      = r_label;
        n_depth      = r_depth;
        n_top_v      = r_top_v;
        n_top_p      = r_top_p;
        n_top_end    = r_top_end;
        n_w          = r_w;
        n_pass       = r_pass;
        n_comp_total = r_comp_total;
        n_hwm        = r_hwm;
        n_o_valid    = 1'b0;
        n_o_res      = r_o_res;
        o_pop        = 1'b0;

        e_we   = 1'b0;
        fo_we  = 1'b0;
        ro_we  = 1'b0;
        fo_wa  = r_i;
        ro_wa  = r_i;
        fo_wd  = '0;
        ro_wd  = '0;
        fo_ra0 = r_i;
        ro_ra0 = r_i;
        fo_ra1 = {1'b0, r_top_v} + CNT_W'(1);
        ro_ra1 = {1'b0, r_top_v} + CNT_W'(1);
        ff_we  = 1'b0;
        rf_we  = 1'b0;
        ff_wa  = s;
        rf_wa  = t;
        ff_wd  = r_ff_rd + OFF_W'(1);
        rf_wd  = r_rf_rd + OFF_W'(1);
        ff_ra  = s;
        rf_ra  = t;
        fl_we  = 1'b0;
        rl_we  = 1'b0;
        fl_wa  = r_ff_rd[EDGE_AW-1:0];
        rl_wa  = r_rf_rd[EDGE_AW-1:0];
        fl_wd  = t;
        rl_wd  = s;
        lst_ra = r_top_p[EDGE_AW-1:0];
        vis_we = 1'b0;
        vis_wa = r_i[NODE_W-1:0];
        vis_wd = 1'b0;
        vis_ra = r_i[NODE_W-1:0];
        fin_we = 1'b0;
        fin_wa = r_fin_cnt[NODE_W-1:0];
        fin_wd = r_top_v;
        fin_ra = NODE_W'(r_i - CNT_W'(1));
        stk_we = 1'b0;
        stk_wa = NODE_W'(r_depth - CNT_W'(1));
        stk_wd = '{node: r_top_v, pos: r_top_p, fin: r_top_end};
        stk_ra = NODE_W'(r_depth - CNT_W'(2));
        cp_we  = 1'b0;
        cp_wa  = r_top_v;
        cp_wd  = r_label[NODE_W-1:0];

        unique case (r_state)
            ES_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_head.cmd;
                    unique case (i_head.cmd.op)
                        REQ_SOLVE: begin
                            n_n     = i_nodes;
                            n_i     = '0;
                            n_state = ES_CLR;
                        end
                        REQ_QUERY: n_state = ES_QRY_RD;
                        REQ_ADD,
                        REQ_NONE:  n_state = ES_REPLY;
                    endcase
                end
            end

            // edge load and unused code
            ES_REPLY: begin
                n_o_valid = 1'b1;
                n_o_res   = '{status: STAT_OK, component_total: r_comp_total,
                              first_component: '0, second_component: '0,
                              same_component: 1'b0};
                if (r_cmd.op == REQ_ADD) begin
                    if (r_cmd.range_err) begin
                        n_o_res.status = STAT_RANGE;
                    end else if (r_edge_total == EDGE_CW'(MAX_EDGES)) begin
                        n_o_res.status = STAT_FULL;
                    end else begin
                        e_we         = 1'b1;
                        n_edge_total = r_edge_total + EDGE_CW'(1);
                    end
                end
                n_state = ES_IDLE;
            end

            ES_QRY_RD: n_state = ES_QRY_OUT;

            ES_QRY_OUT: begin
                n_o_valid = 1'b1;
                n_o_res   = '{status: STAT_OK, component_total: r_comp_total,
                              first_component: q_c1, second_component: q_c2,
                              same_component: (q_c1 == q_c2)};
                if (r_cmd.range_err) begin
                    n_o_res.status           = STAT_RANGE;
                    n_o_res.first_component  = '0;
                    n_o_res.second_component = '0;
                    n_o_res.same_component   = 1'b0;
                end
                n_state = ES_IDLE;
            end

            // clear offsets and visited flags
            ES_CLR: begin
                fo_we  = 1'b1;
                ro_we  = 1'b1;
                vis_we = 1'b1;
                n_i    = r_i + CNT_W'(1);
                if (r_i == r_n) begin
                    n_e = '0;
                    if (r_edge_total != '0) begin
                        n_state = ES_CNT_RD;
                    end else if (r_n == '0) begin
                        n_i       = '0;
                        n_fin_cnt = '0;
                        n_pass    = 1'b0;
                        n_state   = ES_OUT_RD;
                    end else begin
                        n_i     = CNT_W'(1);
                        n_sum_f = '0;
                        n_sum_r = '0;
                        n_state = ES_PRE_RD;
                    end
                end
            end

            // count degrees
            ES_CNT_RD: n_state = ES_CNT_W;

            ES_CNT_W: begin
                fo_ra0  = {1'b0, s} + CNT_W'(1);
                ro_ra0  = {1'b0, t} + CNT_W'(1);
                n_state = ES_CNT_UPD;
            end

            ES_CNT_UPD: begin
                fo_wa = {1'b0, s} + CNT_W'(1);
                ro_wa = {1'b0, t} + CNT_W'(1);
                fo_wd = r_fo_rd0 + OFF_W'(1);
                ro_wd = r_ro_rd0 + OFF_W'(1);
                fo_we = edge_ok;
                ro_we = edge_ok;
                n_e   = r_e + EDGE_CW'(1);
                if (n_e == r_edge_total) begin
                    if (r_n == '0) begin
                        n_i       = '0;
                        n_fin_cnt = '0;
                        n_pass    = 1'b0;
                        n_state   = ES_OUT_RD;
                    end else begin
                        n_i     = CNT_W'(1);
                        n_sum_f = '0;
                        n_sum_r = '0;
                        n_state = ES_PRE_RD;
                    end
                end else begin
                    n_state = ES_CNT_RD;
                end
            end

            // running sum into offsets, start points into fill pointers
            ES_PRE_RD: n_state = ES_PRE_WR;

            ES_PRE_WR: begin
                fo_we   = 1'b1;
                ro_we   = 1'b1;
                fo_wd   = r_fo_rd0 + r_sum_f;
                ro_wd   = r_ro_rd0 + r_sum_r;
                ff_we   = 1'b1;
                rf_we   = 1'b1;
                ff_wa   = NODE_W'(r_i - CNT_W'(1));
                rf_wa   = NODE_W'(r_i - CNT_W'(1));
                ff_wd   = r_sum_f;
                rf_wd   = r_sum_r;
                n_sum_f = r_fo_rd0 + r_sum_f;
                n_sum_r = r_ro_rd0 + r_sum_r;
                n_i     = r_i + CNT_W'(1);
                if (r_i == r_n) begin
                    if (r_edge_total != '0) begin
                        n_e     = '0;
                        n_state = ES_PLC_RD;
                    end else begin
                        n_i       = '0;
                        n_fin_cnt = '0;
                        n_pass    = 1'b0;
                        n_state   = ES_OUT_RD;
                    end
                end else begin
                    n_state = ES_PRE_RD;
                end
            end

            // place edges into the lists
            ES_PLC_RD: n_state = ES_PLC_W;

            ES_PLC_W: n_state = ES_PLC_UPD;

            ES_PLC_UPD: begin
                fl_we = edge_ok;
                rl_we = edge_ok;
                ff_we = edge_ok;
                rf_we = edge_ok;
                n_e   = r_e + EDGE_CW'(1);
                if (n_e == r_edge_total) begin
                    n_i       = '0;
                    n_fin_cnt = '0;
                    n_pass    = 1'b0;
                    n_state   = ES_OUT_RD;
                end else begin
                    n_state = ES_PLC_RD;
                end
            end

            // forward pass: start nodes in ascending order
            ES_OUT_RD: begin
                if (r_i == r_n) begin
                    n_i     = '0;
                    n_state = ES_VCLR;
                end else begin
                    n_state = ES_OUT_W;
                end
            end

            ES_OUT_W: begin
                if (r_vis_rd) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ES_OUT_RD;
                end else begin
                    n_top_v = r_i[NODE_W-1:0];
                    n_state = ES_START;
                end
            end

            // root of a walk
            ES_START: begin
                vis_we  = 1'b1;
                vis_wa  = r_top_v;
                vis_wd  = 1'b1;
                cp_we   = r_pass;
                fo_ra0  = {1'b0, r_top_v};
                ro_ra0  = {1'b0, r_top_v};
                n_depth = CNT_W'(1);
                n_state = ES_LOAD;
            end

            ES_LOAD: begin
                n_top_p   = cur_off0;
                n_top_end = cur_off1;
                n_state   = ES_STEP;
            end

            // next neighbour or finish the top node
            ES_STEP: begin
                if (r_top_p < r_top_end) begin
                    n_top_p = r_top_p + OFF_W'(1);
                    n_state = ES_STEP_W;
                end else begin
                    if (!r_pass) begin
                        fin_we    = 1'b1;
                        n_fin_cnt = r_fin_cnt + CNT_W'(1);
                    end
                    n_depth = r_depth - CNT_W'(1);
                    if (r_depth == CNT_W'(1)) begin
                        if (!r_pass) begin
                            n_i     = r_i + CNT_W'(1);
                            n_state = ES_OUT_RD;
                        end else begin
                            n_label = r_label + CNT_W'(1);
                            n_i     = r_i - CNT_W'(1);
                            n_state = ES_FIN_RD;
                        end
                    end else begin
                        n_state = ES_POP_W;
                    end
                end
            end

            ES_POP_W: begin
                n_top_v   = r_stk_rd.node;
                n_top_p   = r_stk_rd.pos;
                n_top_end = r_stk_rd.fin;
                n_state   = ES_STEP;
            end

            ES_STEP_W: begin
                n_w     = cur_list;
                vis_ra  = cur_list;
                n_state = ES_VIS_W;
            end

            // descend into an unvisited neighbour
            ES_VIS_W: begin
                if (r_vis_rd) begin
                    n_state = ES_STEP;
                end else begin
                    stk_we  = 1'b1;
                    vis_we  = 1'b1;
                    vis_wa  = r_w;
                    vis_wd  = 1'b1;
                    cp_we   = r_pass;
                    cp_wa   = r_w;
                    fo_ra0  = {1'b0, r_w};
                    ro_ra0  = {1'b0, r_w};
                    fo_ra1  = {1'b0, r_w} + CNT_W'(1);
                    ro_ra1  = {1'b0, r_w} + CNT_W'(1);
                    n_top_v = r_w;
                    n_depth = r_depth + CNT_W'(1);
                    n_state = ES_LOAD;
                end
            end

            // clear visited flags between passes
            ES_VCLR: begin
                vis_we = 1'b1;
                n_i    = r_i + CNT_W'(1);
                if (n_i >= r_n) begin
                    n_pass  = 1'b1;
                    n_label = '0;
                    n_i     = r_fin_cnt;
                    n_state = ES_FIN_RD;
                end
            end

            // reverse pass: start nodes in reverse finish order
            ES_FIN_RD: begin
                if (r_i == '0) begin
                    n_state = ES_DONE;
                end else begin
                    n_state = ES_FIN_W;
                end
            end

            ES_FIN_W: begin
                vis_ra  = r_fin_rd;
                n_state = ES_REV_VIS;
            end

            ES_REV_VIS: begin
                if (r_vis_rd) begin
                    n_i     = r_i - CNT_W'(1);
                    n_state = ES_FIN_RD;
                end else begin
                    n_top_v = r_fin_rd;
                    n_state = ES_START;
                end
            end

            ES_DONE: begin
                n_o_valid    = 1'b1;
                n_o_res      = '{status: STAT_OK, component_total: r_label,
                                 first_component: '0, second_component: '0,
                                 same_component: 1'b0};
                n_comp_total = r_label;
                n_pass       = 1'b0;
                if (r_n > r_hwm) begin
                    n_hwm = r_n;
                end
                n_state = ES_IDLE;
            end

            default: n_state = ES_IDLE;
        endcase
    end

    assign o_res_valid = r_o_valid;
    assign o_res_word  = r_o_res;

endmodule
`default_nettype wire

// ===== test/scc_checker.sv =====
`default_nettype none
module scc_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      o_busy,
    input  wire scc_pkg::t_in_word         i_req_word,
    input  wire logic                      i_cfg_we,
    input  wire logic [scc_pkg::CNT_W-1:0] i_cfg_wdata,
    input  wire logic                      o_res_valid,
    input  wire scc_pkg::t_out_word        o_res_word,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import scc_pkg::*;

    // model state
    int node_reg;
    int edge_src[$];
    int edge_tgt[$];
    int comp_of[MAX_NODES];
    int comp_total;

    // scratch for a solve
    int fwd_off[MAX_NODES+1];
    int rev_off[MAX_NODES+1];
    int fwd_adj[MAX_EDGES];
    int rev_adj[MAX_EDGES];
    int finish_seq[MAX_NODES];
    int finish_len;
    int stack_node[MAX_NODES];
    int stack_pos[MAX_NODES];
    bit seen[MAX_NODES];

    t_out_word result_q[$];

    assign o_pending = result_q.size();

    task report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function int live_nodes();
        return node_reg > MAX_NODES ? MAX_NODES : node_reg;
    endfunction

    // depth-first walk; forward records finish order, reverse labels nodes
    function void dfs_walk(input int start, input bit fwd, input int label);
        int depth, v, p, w, lim;
        depth = 1;
        seen[start] = 1'b1;
        stack_node[0] = start;
        stack_pos[0] = fwd ? fwd_off[start] : rev_off[start];
        if (!fwd) comp_of[start] = label;
        while (depth > 0) begin
            v = stack_node[depth-1];
            p = stack_pos[depth-1];
            lim = fwd ? fwd_off[v+1] : rev_off[v+1];
            if (p < lim) begin
                w = fwd ? fwd_adj[p] : rev_adj[p];
                stack_pos[depth-1] = p + 1;
                if (!seen[w]) begin
                    seen[w] = 1'b1;
                    if (!fwd) comp_of[w] = label;
                    stack_node[depth] = w;
                    stack_pos[depth] = fwd ? fwd_off[w] : rev_off[w];
                    depth++;
                end
            end else begin
                depth--;
                if (fwd) begin
                    finish_seq[finish_len] = v;
                    finish_len++;
                end
            end
        end
    endfunction

    // Kosaraju over edges with both ends below the node count
    function void solve_components();
        int n, i, k, s, t, cnt;
        int fill_f[MAX_NODES];
        int fill_r[MAX_NODES];
        n = live_nodes();
        for (i = 0; i <= MAX_NODES; i++) begin
            fwd_off[i] = 0;
            rev_off[i] = 0;
        end
        foreach (edge_src[e]) begin
            s = edge_src[e];
            t = edge_tgt[e];
            if (s < n && t < n) begin
                fwd_off[s+1]++;
                rev_off[t+1]++;
            end
        end
        for (i = 0; i < n; i++) begin
            fwd_off[i+1] += fwd_off[i];
            rev_off[i+1] += rev_off[i];
            fill_f[i] = fwd_off[i];
            fill_r[i] = rev_off[i];
        end
        foreach (edge_src[e]) begin
            s = edge_src[e];
            t = edge_tgt[e];
            if (s < n && t < n) begin
                fwd_adj[fill_f[s]] = t;
                fill_f[s]++;
                rev_adj[fill_r[t]] = s;
                fill_r[t]++;
            end
        end
        finish_len = 0;
        for (i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
        for (i = 0; i < n; i++)
            if (!seen[i]) dfs_walk(i, 1'b1, 0);
        for (i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
        cnt = 0;
        for (k = finish_len; k > 0; k--) begin
            if (!seen[finish_seq[k-1]]) begin
                dfs_walk(finish_seq[k-1], 1'b0, cnt);
                cnt++;
            end
        end
        comp_total = cnt;
    endfunction

    // expected result word for one accepted request
    function t_out_word predict_word(input t_in_word w);
        t_out_word r;
        int n, a, b;
        r = '0;
        n = live_nodes();
        a = w.source_node;
        b = w.target_node;
        case (t_req'(w.req_type))
            REQ_ADD: begin
                if (a >= n || b >= n) r.status = STAT_RANGE;
                else if (edge_src.size() >= MAX_EDGES) r.status = STAT_FULL;
                else begin
                    edge_src.push_back(a);
                    edge_tgt.push_back(b);
                end
            end
            REQ_SOLVE: solve_components();
            REQ_QUERY: begin
                if (a >= n || b >= n) r.status = STAT_RANGE;
                else begin
                    r.first_component = NODE_W'(comp_of[a]);
                    r.second_component = NODE_W'(comp_of[b]);
                    r.same_component = (comp_of[a] == comp_of[b]);
                end
            end
            default: ;
        endcase
        r.component_total = CNT_W'(comp_total);
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            node_reg = 0;
            comp_total = 0;
            edge_src.delete();
            edge_tgt.delete();
            for (int i = 0; i < MAX_NODES; i++) comp_of[i] = 0;
            result_q.delete();
            o_fail_count = 0;
        end else begin
            if (o_res_valid) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = result_q.pop_front();
                    if (o_res_word.status !== want.status)
                        report_mismatch("status", o_res_word.status, want.status);
                    if (o_res_word.component_total !== want.component_total)
                        report_mismatch("component_total", o_res_word.component_total,
                                        want.component_total);
                    if (o_res_word.first_component !== want.first_component)
                        report_mismatch("first_component", o_res_word.first_component,
                                        want.first_component);
                    if (o_res_word.second_component !== want.second_component)
                        report_mismatch("second_component", o_res_word.second_component,
                                        want.second_component);
                    if (o_res_word.same_component !== want.same_component)
                        report_mismatch("same_component", o_res_word.same_component,
                                        want.same_component);
                end
            end
            if (i_start && !o_busy) result_q.push_back(predict_word(i_req_word));
            if (i_cfg_we) node_reg = int'(i_cfg_wdata);
        end
    end

endmodule
`default_nettype wire

// ===== test/strongly_connected_components_unit_tb.sv =====
`default_nettype none
module strongly_connected_components_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scc_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_in_word         i_req_word;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             o_res_valid;
    t_out_word        o_res_word;
    int               fail_count;
    int               pending;

    int  cur_nodes;
    bit  steady;

    strongly_connected_components_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req_word  (i_req_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (o_res_valid),
        .o_res_word  (o_res_word)
    );

    scc_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req_word   (i_req_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_valid  (o_res_valid),
        .o_res_word   (o_res_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // present one request word and hold it until taken
    task automatic push_word(input t_req op, input int a, input int b);
        t_in_word w;
        w.req_type = op;
        w.source_node = a[NODE_W-1:0];
        w.target_node = b[NODE_W-1:0];
        i_req_word <= w;
        i_start <= 1'b1;
        do @(negedge i_clk); while (o_busy);
        @(posedge i_clk);
        if (!steady && $urandom_range(0, 99) < 25) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // stop sending, then wait until the checker holds no pending result word
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // node count register, written only once the block has gone quiet
    task automatic set_nodes(input int v);
        drain();
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_nodes = v > MAX_NODES ? MAX_NODES : v;
    endtask

    function automatic int pick_node(input int mostly_valid_pct);
        if (cur_nodes > 0 && $urandom_range(0, 99) < mostly_valid_pct)
            return $urandom_range(0, cur_nodes - 1);
        return $urandom_range(0, MAX_NODES - 1);
    endfunction

    // random traffic: mostly in-range edges and queries, the odd solve
    task automatic random_run(input int count, input int solve_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < solve_pct) push_word(REQ_SOLVE, $urandom_range(0, 1023),
                                         $urandom_range(0, 1023));
            else if (r < solve_pct + 40) push_word(REQ_ADD, pick_node(90), pick_node(90));
            else if (r < solve_pct + 94) push_word(REQ_QUERY, pick_node(92), pick_node(92));
            else if (r < solve_pct + 97) push_word(REQ_NONE, $urandom_range(0, 1023),
                                                   $urandom_range(0, 1023));
            else begin
                drain();
                push_word(REQ_QUERY, pick_node(90), pick_node(90));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        cur_nodes = 0;
        steady = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no nodes: everything out of range, empty solve, unused code
        push_word(REQ_ADD, 0, 0);
        push_word(REQ_QUERY, 0, 1023);
        push_word(REQ_SOLVE, 0, 0);
        push_word(REQ_NONE, 1023, 1023);

        // small graph: query before solve, cycle, self loop, range errors
        set_nodes(5);
        push_word(REQ_QUERY, 4, 0);
        push_word(REQ_ADD, 0, 1);
        push_word(REQ_ADD, 1, 2);
        push_word(REQ_ADD, 2, 0);
        push_word(REQ_ADD, 3, 4);
        push_word(REQ_ADD, 4, 4);
        push_word(REQ_ADD, 5, 0);
        push_word(REQ_ADD, 0, 1023);
        push_word(REQ_SOLVE, 0, 0);
        push_word(REQ_QUERY, 0, 2);
        push_word(REQ_QUERY, 3, 4);
        push_word(REQ_QUERY, 1, 5);
        push_word(REQ_NONE, 2, 3);

        // shrink: edges into node 4 go stale, queries of node 4 are out of range
        set_nodes(4);
        push_word(REQ_SOLVE, 0, 0);
        push_word(REQ_QUERY, 3, 0);
        push_word(REQ_QUERY, 4, 4);

        // random phases over several node counts, saturation included
        set_nodes(8);
        random_run(320, 3);
        set_nodes(30);
        steady = 1'b1;
        random_run(150, 3);
        steady = 1'b0;
        random_run(170, 3);
        set_nodes(MAX_NODES);
        random_run(300, 1);
        set_nodes(1);
        random_run(250, 3);
        set_nodes(2047);
        random_run(300, 1);
        set_nodes(100);
        random_run(430, 2);

        // out-of-range edge, then solves over a small and the full node range
        set_nodes(16);
        push_word(REQ_ADD, 16, 3);
        push_word(REQ_SOLVE, 0, 0);
        push_word(REQ_QUERY, 0, 15);
        set_nodes(MAX_NODES);
        push_word(REQ_SOLVE, 0, 0);
        push_word(REQ_QUERY, 1023, 0);
        push_word(REQ_QUERY, 15, 512);

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
